>>> hdl/prs_pkg.sv
// Shared constants, types and control records of the packet rate shaper.
`default_nettype none

package prs_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int LEN_W = 16;
   localparam int FRAME_W = 64;
   localparam int TIME_W = 64;
   localparam int RATE_W = 34;
   localparam int WIN_W = 24;
   localparam int DEBT_W = 25;
   localparam int BUF_W = 22;
   localparam int TOTAL_W = LEN_W + CNT_W;
   localparam int WORD_W = LEN_W + FRAME_W;

   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = RATE_W;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW = 1'd1;

   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_SEND = 1'b1;

   localparam logic [WIN_W-1:0] MIN_WINDOW = 24'd2000;
   localparam logic [DEBT_W-1:0] DEBT_MAX = {DEBT_W{1'b1}};
   localparam logic [BUF_W-1:0] BUF_MAX = {BUF_W{1'b1}};

   // Drain arithmetic: quotient by one million of rate times elapsed time.
   localparam int US_W = 20;
   localparam logic [US_W-1:0] US_PER_SEC = 20'd1000000;
   localparam int QUOT_W = DEBT_W;
   localparam int ELAPSED_W = QUOT_W + US_W;
   localparam int SPLIT_W = 23;
   localparam int PROD_LO_W = RATE_W + SPLIT_W;
   localparam int PROD_HI_W = RATE_W + ELAPSED_W - SPLIT_W;
   localparam int X_W = RATE_W + ELAPSED_W;
   localparam int DPROD_W = DEBT_W + US_W;

   // Division by one million: the six low bits are dropped, then the division by
   // 15625 uses a truncated reciprocal whose estimate is low by at most one.
   localparam int DIV_SHIFT = 6;
   localparam int Y_W = ELAPSED_W - DIV_SHIFT;
   localparam logic [13:0] DIV_ODD = 14'd15625;
   localparam int XHI_LSB = 19;
   localparam int RECIP_W = 25;
   localparam int RECIP_SHIFT = 25;
   localparam logic [RECIP_W-1:0] RECIP_M = 25'd17592186;
   localparam int RPROD_W = ELAPSED_W - XHI_LSB + RECIP_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_SUM,
      ST_CMP,
      ST_DIV,
      ST_FIX,
      ST_DRAIN,
      ST_DECIDE,
      ST_OUTPUT
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic simple;
      logic drain_hold;
      logic mul_lo;
      logic mul_hi;
      logic sum;
      logic cmp;
      logic div_step;
      logic div_fix;
      logic drain_sub;
      logic decide;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic mode_send;
      logic queue_empty;
      logic rate_zero;
      logic skip_div;
      logic rsp_free;
   } dp_status_type;

endpackage

`default_nettype wire

>>> hdl/prs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module prs_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                   clock,
   input  wire logic                   write_en,
   input  wire logic [ADDR_W-1:0]      write_addr,
   input  wire logic [DATA_W-1:0]      write_data,
   input  wire logic [ADDR_W-1:0]      read_addr,
   output logic      [DATA_W-1:0]      read_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire

>>> hdl/prs_ctrl.sv
// Sequencer that steps one item at a time through the shaper datapath.
`default_nettype none

module prs_ctrl
   import prs_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (!status.mode_send || status.queue_empty) begin
               state_in = ST_OUTPUT;
            end else if (status.rate_zero) begin
               state_in = ST_DECIDE;
            end else begin
               state_in = ST_MUL_LO;
            end
         end
         ST_MUL_LO: state_in = ST_MUL_HI;
         ST_MUL_HI: state_in = ST_SUM;
         ST_SUM: state_in = ST_CMP;
         ST_CMP: begin
            state_in = status.skip_div ? ST_DECIDE : ST_DIV;
         end
         ST_DIV: state_in = ST_FIX;
         ST_FIX: state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_DECIDE;
         ST_DECIDE: state_in = ST_OUTPUT;
         ST_OUTPUT: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.capture = req_valid;
         end
         ST_DECODE: begin
            cmd.simple = !status.mode_send || status.queue_empty;
            cmd.drain_hold = status.mode_send && !status.queue_empty && status.rate_zero;
         end
         ST_MUL_LO: cmd.mul_lo = 1'b1;
         ST_MUL_HI: cmd.mul_hi = 1'b1;
         ST_SUM: cmd.sum = 1'b1;
         ST_CMP: cmd.cmp = 1'b1;
         ST_DIV: cmd.div_step = 1'b1;
         ST_FIX: cmd.div_fix = 1'b1;
         ST_DRAIN: cmd.drain_sub = 1'b1;
         ST_DECIDE: cmd.decide = 1'b1;
         ST_OUTPUT: cmd.load_rsp = status.rsp_free;
         default: cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

>>> hdl/prs_dp.sv
// Datapath: descriptor queue, shaper state, drain arithmetic and result register.
`default_nettype none

module prs_dp
   import prs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ctrl_cmd_type          cmd,
   output dp_status_type              status,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_mode,
   input  wire logic [LEN_W-1:0]      req_packet_len,
   input  wire logic [FRAME_W-1:0]    req_frame_number,
   input  wire logic [TIME_W-1:0]     req_now_us,
   input  wire logic                  req_link_accepts,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_sent,
   output logic [LEN_W-1:0]           rsp_sent_len,
   output logic [FRAME_W-1:0]         rsp_sent_frame,
   output logic                       rsp_overflow,
   output logic                       rsp_queue_empty,
   output logic [BUF_W-1:0]           rsp_buffered_bytes,
   output logic [DEBT_W-1:0]          rsp_debt_bytes
);

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   // Control state with reset.
   logic [RATE_W-1:0]  rate_ff, rate_in;
   logic [WIN_W-1:0]   window_ff, window_in;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [DEBT_W-1:0]  debt_ff, debt_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [TIME_W-1:0]  last_time_ff, last_time_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic               mode_ff, mode_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic               accepts_ff, accepts_in;
   logic [TIME_W-1:0]  elapsed_ff, elapsed_in;
   logic [PROD_LO_W-1:0] prod_lo_ff, prod_lo_in;
   logic [PROD_HI_W-1:0] prod_hi_ff, prod_hi_in;
   logic [DPROD_W-1:0] dprod_ff, dprod_in;
   logic               big_ff, big_in;
   logic [X_W-1:0]     x_ff, x_in;
   logic [QUOT_W-1:0]  quo_ff, quo_in;
   logic [DEBT_W-1:0]  drain_ff, drain_in;
   logic               res_sent_ff, res_sent_in;
   logic [LEN_W-1:0]   res_len_ff, res_len_in;
   logic [FRAME_W-1:0] res_frame_ff, res_frame_in;
   logic               res_ovf_ff, res_ovf_in;
   logic               out_sent_ff, out_sent_in;
   logic [LEN_W-1:0]   out_len_ff, out_len_in;
   logic [FRAME_W-1:0] out_frame_ff, out_frame_in;
   logic               out_ovf_ff, out_ovf_in;
   logic               out_empty_ff, out_empty_in;
   logic [BUF_W-1:0]   out_buf_ff, out_buf_in;
   logic [DEBT_W-1:0]  out_debt_ff, out_debt_in;

   logic               ram_we;
   logic [WORD_W-1:0]  ram_rdata;
   logic [LEN_W-1:0]   head_len;
   logic [FRAME_W-1:0] head_frame;
   logic               queue_full;
   logic               queue_empty;
   logic               skip_div;
   logic [RPROD_W-1:0] recip_prod;
   logic [Y_W-1:0]     fix_rem;
   logic               allowed;
   logic               go;
   logic [DEBT_W:0]    debt_sum;
   logic [TOTAL_W+BUF_W-1:0] total_wide;

   prs_ram #(
      .DATA_W(WORD_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue_ram (
      .clock(clock),
      .write_en(ram_we),
      .write_addr(tail_ff),
      .write_data({len_ff, frame_ff}),
      .read_addr(head_ff),
      .read_data(ram_rdata)
   );

   assign head_len = ram_rdata[WORD_W-1:FRAME_W];
   assign head_frame = ram_rdata[FRAME_W-1:0];
   assign queue_full = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign queue_empty = (count_ff == '0);
   assign skip_div = big_ff || (x_ff >= X_W'(dprod_ff));
   assign recip_prod = RPROD_W'(x_ff[ELAPSED_W-1:XHI_LSB]) * RPROD_W'(RECIP_M);
   assign fix_rem = x_ff[ELAPSED_W-1:DIV_SHIFT] - Y_W'(quo_ff) * Y_W'(DIV_ODD);
   assign allowed = (rate_ff == '0) || (drain_ff <= DEBT_W'(window_ff));
   assign go = allowed && accepts_ff;
   assign debt_sum = {1'b0, drain_ff} + (DEBT_W+1)'(head_len);
   assign total_wide = (TOTAL_W+BUF_W)'(total_ff);
   assign ram_we = cmd.simple && (mode_ff == MODE_PUSH) && !queue_full;

   assign status.mode_send = (mode_ff == MODE_SEND);
   assign status.queue_empty = queue_empty;
   assign status.rate_zero = (rate_ff == '0);
   assign status.skip_div = skip_div;
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rate_in = rate_ff;
      window_in = window_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      count_in = count_ff;
      debt_in = debt_ff;
      total_in = total_ff;
      last_time_in = last_time_ff;
      rsp_valid_in = rsp_valid_ff;
      mode_in = mode_ff;
      len_in = len_ff;
      frame_in = frame_ff;
      now_in = now_ff;
      accepts_in = accepts_ff;
      elapsed_in = elapsed_ff;
      prod_lo_in = prod_lo_ff;
      prod_hi_in = prod_hi_ff;
      dprod_in = dprod_ff;
      big_in = big_ff;
      x_in = x_ff;
      quo_in = quo_ff;
      drain_in = drain_ff;
      res_sent_in = res_sent_ff;
      res_len_in = res_len_ff;
      res_frame_in = res_frame_ff;
      res_ovf_in = res_ovf_ff;
      out_sent_in = out_sent_ff;
      out_len_in = out_len_ff;
      out_frame_in = out_frame_ff;
      out_ovf_in = out_ovf_ff;
      out_empty_in = out_empty_ff;
      out_buf_in = out_buf_ff;
      out_debt_in = out_debt_ff;

      if (csr_write_en) begin
         case (csr_index)
            CSR_RATE: rate_in = csr_wdata[RATE_W-1:0];
            CSR_WINDOW: begin
               window_in = (csr_wdata[WIN_W-1:0] < MIN_WINDOW) ?
                           MIN_WINDOW : csr_wdata[WIN_W-1:0];
            end
            default: rate_in = rate_ff;
         endcase
      end

      if (cmd.capture) begin
         mode_in = req_mode;
         len_in = req_packet_len;
         frame_in = req_frame_number;
         now_in = req_now_us;
         accepts_in = req_link_accepts;
         elapsed_in = req_now_us - last_time_ff;
      end

      if (cmd.simple) begin
         res_sent_in = 1'b0;
         res_len_in = '0;
         res_frame_in = '0;
         res_ovf_in = (mode_ff == MODE_PUSH) && queue_full;
         if (ram_we) begin
            tail_in = next_ptr(tail_ff);
            count_in = count_ff + CNT_W'(1);
            total_in = total_ff + TOTAL_W'(len_ff);
         end
      end

      if (cmd.drain_hold) begin
         drain_in = debt_ff;
      end

      if (cmd.mul_lo) begin
         prod_lo_in = PROD_LO_W'(rate_ff) * PROD_LO_W'(elapsed_ff[SPLIT_W-1:0]);
         dprod_in = DPROD_W'(debt_ff) * DPROD_W'(US_PER_SEC);
         big_in = |elapsed_ff[TIME_W-1:ELAPSED_W];
      end

      if (cmd.mul_hi) begin
         prod_hi_in = PROD_HI_W'(rate_ff) * PROD_HI_W'(elapsed_ff[ELAPSED_W-1:SPLIT_W]);
      end

      if (cmd.sum) begin
         x_in = X_W'(prod_lo_ff) + {prod_hi_ff, {SPLIT_W{1'b0}}};
      end

      // A drain at least as large as the debt empties it; otherwise the
      // product is below the debt times one million and the quotient fits
      // in the debt width.
      if (cmd.cmp) begin
         if (skip_div) begin
            drain_in = '0;
         end
      end

      if (cmd.div_step) begin
         quo_in = recip_prod[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
      end

      // The reciprocal estimate is low by at most one.
      if (cmd.div_fix) begin
         quo_in = quo_ff + QUOT_W'(fix_rem >= Y_W'(DIV_ODD));
      end

      if (cmd.drain_sub) begin
         drain_in = debt_ff - quo_ff;
      end

      if (cmd.decide) begin
         res_sent_in = go;
         res_len_in = allowed ? head_len : '0;
         res_frame_in = allowed ? head_frame : '0;
         res_ovf_in = 1'b0;
         if (rate_ff != '0) begin
            last_time_in = now_ff;
         end
         if (go) begin
            debt_in = debt_sum[DEBT_W] ? DEBT_MAX : debt_sum[DEBT_W-1:0];
            head_in = next_ptr(head_ff);
            count_in = count_ff - CNT_W'(1);
            total_in = total_ff - TOTAL_W'(head_len);
         end else begin
            debt_in = drain_ff;
         end
      end

      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         out_sent_in = res_sent_ff;
         out_len_in = res_len_ff;
         out_frame_in = res_frame_ff;
         out_ovf_in = res_ovf_ff;
         out_empty_in = queue_empty;
         out_buf_in = (total_wide > (TOTAL_W+BUF_W)'(BUF_MAX)) ?
                      BUF_MAX : total_wide[BUF_W-1:0];
         out_debt_in = debt_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= '0;
         window_ff <= MIN_WINDOW;
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
         debt_ff <= '0;
         total_ff <= '0;
         last_time_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rate_ff <= rate_in;
         window_ff <= window_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         count_ff <= count_in;
         debt_ff <= debt_in;
         total_ff <= total_in;
         last_time_ff <= last_time_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      len_ff <= len_in;
      frame_ff <= frame_in;
      now_ff <= now_in;
      accepts_ff <= accepts_in;
      elapsed_ff <= elapsed_in;
      prod_lo_ff <= prod_lo_in;
      prod_hi_ff <= prod_hi_in;
      dprod_ff <= dprod_in;
      big_ff <= big_in;
      x_ff <= x_in;
      quo_ff <= quo_in;
      drain_ff <= drain_in;
      res_sent_ff <= res_sent_in;
      res_len_ff <= res_len_in;
      res_frame_ff <= res_frame_in;
      res_ovf_ff <= res_ovf_in;
      out_sent_ff <= out_sent_in;
      out_len_ff <= out_len_in;
      out_frame_ff <= out_frame_in;
      out_ovf_ff <= out_ovf_in;
      out_empty_ff <= out_empty_in;
      out_buf_ff <= out_buf_in;
      out_debt_ff <= out_debt_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_sent = out_sent_ff;
   assign rsp_sent_len = out_len_ff;
   assign rsp_sent_frame = out_frame_ff;
   assign rsp_overflow = out_ovf_ff;
   assign rsp_queue_empty = out_empty_ff;
   assign rsp_buffered_bytes = out_buf_ff;
   assign rsp_debt_bytes = out_debt_ff;

endmodule

`default_nettype wire

>>> hdl/packet_rate_shaper_top.sv
// Top level of the packet rate shaper: sequencer, datapath and checks.
// A push or a send on an empty queue goes from decode straight to the result register.
// A send with rate zero passes through the decision step before its result.
// A shaped send passes through the partial products, the sum, the comparison and
// the reciprocal division by one million, which it skips when the drain clears the whole debt.
// Synchronous reset empties the queue, clears debt, time and rate, and sets the window to 2000.
`default_nettype none

module packet_rate_shaper_top
   import prs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_mode,
   input  wire logic [LEN_W-1:0]      req_packet_len,
   input  wire logic [FRAME_W-1:0]    req_frame_number,
   input  wire logic [TIME_W-1:0]     req_now_us,
   input  wire logic                  req_link_accepts,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_sent,
   output logic [LEN_W-1:0]           rsp_sent_len,
   output logic [FRAME_W-1:0]         rsp_sent_frame,
   output logic                       rsp_overflow,
   output logic                       rsp_queue_empty,
   output logic [BUF_W-1:0]           rsp_buffered_bytes,
   output logic [DEBT_W-1:0]          rsp_debt_bytes
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   prs_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .status(status),
      .cmd(cmd)
   );

   prs_dp u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_mode(req_mode),
      .req_packet_len(req_packet_len),
      .req_frame_number(req_frame_number),
      .req_now_us(req_now_us),
      .req_link_accepts(req_link_accepts),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_sent(rsp_sent),
      .rsp_sent_len(rsp_sent_len),
      .rsp_sent_frame(rsp_sent_frame),
      .rsp_overflow(rsp_overflow),
      .rsp_queue_empty(rsp_queue_empty),
      .rsp_buffered_bytes(rsp_buffered_bytes),
      .rsp_debt_bytes(rsp_debt_bytes)
   );

   a_one_item_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item accepted while one is in progress");

   a_sent_not_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sent |-> !rsp_overflow)
      else $error("item reports both a send and an overflow");

   a_empty_no_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_queue_empty |-> rsp_buffered_bytes == '0)
      else $error("empty queue reports buffered bytes");

   a_overflow_not_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> !rsp_queue_empty)
      else $error("overflow reported with an empty queue");

endmodule

`default_nettype wire

>>> dv/packet_rate_shaper_top_tb.sv
// Self-checking testbench for the packet rate shaper, with a built-in queue and shaping predictor.
module packet_rate_shaper_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import prs_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD = 400;
   localparam int MAX_REPORTS = 10;
   localparam int SETTLE_CYCLES = 50;
   localparam int PHASE_ITEMS = 75;
   localparam int EXPECTED_DEPTH = 8;

   typedef struct packed {
      logic               mode;
      logic [LEN_W-1:0]   len;
      logic [FRAME_W-1:0] frame;
      logic [TIME_W-1:0]  now;
      logic               accepts;
   } shaper_req_t;

   typedef struct packed {
      logic               sent;
      logic [LEN_W-1:0]   sent_len;
      logic [FRAME_W-1:0] sent_frame;
      logic               overflow;
      logic               queue_empty;
      logic [BUF_W-1:0]   buffered;
      logic [DEBT_W-1:0]  debt;
   } shaper_rsp_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_RATE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_mode = MODE_PUSH;
   logic [LEN_W-1:0]      req_packet_len = '0;
   logic [FRAME_W-1:0]    req_frame_number = '0;
   logic [TIME_W-1:0]     req_now_us = '0;
   logic                  req_link_accepts = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_sent;
   logic [LEN_W-1:0]      rsp_sent_len;
   logic [FRAME_W-1:0]    rsp_sent_frame;
   logic                  rsp_overflow;
   logic                  rsp_queue_empty;
   logic [BUF_W-1:0]      rsp_buffered_bytes;
   logic [DEBT_W-1:0]     rsp_debt_bytes;

   // Predictor state.
   logic [LEN_W-1:0]   queued_len [QUEUE_DEPTH];
   logic [FRAME_W-1:0] queued_frame [QUEUE_DEPTH];
   int unsigned        queue_head = 0;
   int unsigned        queue_tail = 0;
   int unsigned        queue_count = 0;
   logic [63:0]        shaper_debt = '0;
   logic [63:0]        queued_bytes = '0;
   logic [63:0]        last_send_time = '0;
   logic [RATE_W-1:0]  shaper_rate = '0;
   logic [WIN_W-1:0]   shaper_window = MIN_WINDOW;

   // Results still owed by the block, kept in a small ring.
   shaper_rsp_t expected_results [EXPECTED_DEPTH];
   int unsigned expected_wr = 0;
   int unsigned expected_rd = 0;
   int          mismatch_count = 0;
   int          quiet_cycles = 0;
   int          hold_requests = 0;
   int          holds_served = 0;
   bit          sender_idling = 1'b0;
   bit          receiver_idling = 1'b0;
   logic [63:0] traffic_time = '0;

   packet_rate_shaper_top dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_packet_len     (req_packet_len),
      .req_frame_number   (req_frame_number),
      .req_now_us         (req_now_us),
      .req_link_accepts   (req_link_accepts),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_sent           (rsp_sent),
      .rsp_sent_len       (rsp_sent_len),
      .rsp_sent_frame     (rsp_sent_frame),
      .rsp_overflow       (rsp_overflow),
      .rsp_queue_empty    (rsp_queue_empty),
      .rsp_buffered_bytes (rsp_buffered_bytes),
      .rsp_debt_bytes     (rsp_debt_bytes)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic shaper_rsp_t shaper_predict(shaper_req_t rq);
      shaper_rsp_t rs;
      logic        allowed;
      logic [63:0] elapsed;
      logic [63:0] whole_sec;
      logic [63:0] frac_us;
      logic [63:0] drain;
      rs = '0;
      if (rq.mode == MODE_PUSH) begin
         if (queue_count >= QUEUE_DEPTH) begin
            rs.overflow = 1'b1;
         end else begin
            queued_len[queue_tail] = rq.len;
            queued_frame[queue_tail] = rq.frame;
            queue_tail = (queue_tail + 1) % QUEUE_DEPTH;
            queue_count++;
            queued_bytes += 64'(rq.len);
         end
      end else if (queue_count != 0) begin
         if (shaper_rate == '0) begin
            allowed = 1'b1;
         end else begin
            // The drain is floor(rate * elapsed / 1e6), split so that nothing overflows.
            elapsed = rq.now - last_send_time;
            whole_sec = elapsed / 64'(US_PER_SEC);
            frac_us = elapsed % 64'(US_PER_SEC);
            if (whole_sec >= (64'd1 << DEBT_W)) begin
               shaper_debt = '0;
            end else begin
               drain = 64'(shaper_rate) * whole_sec
                     + (64'(shaper_rate) * frac_us) / 64'(US_PER_SEC);
               shaper_debt = (drain >= shaper_debt) ? 64'd0 : shaper_debt - drain;
            end
            last_send_time = rq.now;
            allowed = (shaper_debt <= 64'(shaper_window));
         end
         if (allowed) begin
            rs.sent_len = queued_len[queue_head];
            rs.sent_frame = queued_frame[queue_head];
            if (rq.accepts) begin
               rs.sent = 1'b1;
               shaper_debt += 64'(rs.sent_len);
               if (shaper_debt > 64'(DEBT_MAX)) begin
                  shaper_debt = 64'(DEBT_MAX);
               end
               queued_bytes -= 64'(rs.sent_len);
               queue_head = (queue_head + 1) % QUEUE_DEPTH;
               queue_count--;
            end
         end
      end
      rs.queue_empty = (queue_count == 0);
      rs.buffered = (queued_bytes > 64'(BUF_MAX)) ? BUF_MAX : queued_bytes[BUF_W-1:0];
      rs.debt = shaper_debt[DEBT_W-1:0];
      return rs;
   endfunction

   task automatic note_mismatch(string what, shaper_rsp_t want, shaper_rsp_t got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("%0t %s: expected sent=%0d len=%0d frame=%h ovf=%0d empty=%0d buf=%0d debt=%0d",
                  $realtime, what, want.sent, want.sent_len, want.sent_frame, want.overflow,
                  want.queue_empty, want.buffered, want.debt);
         $display("%0t %s: actual   sent=%0d len=%0d frame=%h ovf=%0d empty=%0d buf=%0d debt=%0d",
                  $realtime, what, got.sent, got.sent_len, got.sent_frame, got.overflow,
                  got.queue_empty, got.buffered, got.debt);
      end
   endtask

   always @(posedge clock) begin
      shaper_rsp_t observed;
      shaper_rsp_t want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_results[expected_wr % EXPECTED_DEPTH] = shaper_predict('{req_mode,
               req_packet_len, req_frame_number, req_now_us, req_link_accepts});
            expected_wr++;
         end
         if (rsp_valid && rsp_ready) begin
            observed = '{rsp_sent, rsp_sent_len, rsp_sent_frame, rsp_overflow,
                         rsp_queue_empty, rsp_buffered_bytes, rsp_debt_bytes};
            if (expected_wr == expected_rd) begin
               note_mismatch("unexpected item", '0, observed);
            end else begin
               want = expected_results[expected_rd % EXPECTED_DEPTH];
               expected_rd++;
               if (observed !== want) begin
                  note_mismatch("mismatch", want, observed);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // The receiver serves a requested long hold first, else stalls in short bursts if receiver_idling.
   always begin
      @(negedge clock);
      if (hold_requests != holds_served) begin
         rsp_ready = 1'b0;
         repeat (LONG_HOLD) @(negedge clock);
         holds_served++;
         rsp_ready = 1'b1;
      end else if (receiver_idling && $urandom_range(4) == 0) begin
         rsp_ready = 1'b0;
         repeat ($urandom_range(6)) @(negedge clock);
      end else begin
         rsp_ready = 1'b1;
      end
   end

   function automatic shaper_req_t push_req(logic [LEN_W-1:0] len, logic [FRAME_W-1:0] frame);
      return '{MODE_PUSH, len, frame, {$urandom, $urandom}, 1'($urandom_range(1))};
   endfunction

   function automatic shaper_req_t send_req(logic [TIME_W-1:0] now, logic accepts);
      return '{MODE_SEND, 16'($urandom), {$urandom, $urandom}, now, accepts};
   endfunction

   task automatic send_item(shaper_req_t rq);
      @(negedge clock);
      if (sender_idling && $urandom_range(3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_mode = rq.mode;
      req_packet_len = rq.len;
      req_frame_number = rq.frame;
      req_now_us = rq.now;
      req_link_accepts = rq.accepts;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_for_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_wr != expected_rd) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      if (idx == CSR_RATE) begin
         shaper_rate = value[RATE_W-1:0];
      end else begin
         shaper_window = value[WIN_W-1:0];
         if (shaper_window < MIN_WINDOW) begin
            shaper_window = MIN_WINDOW;
         end
      end
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   task automatic set_shaping(logic [CSR_DATA_W-1:0] rate, logic [CSR_DATA_W-1:0] window);
      wait_for_idle();
      write_csr(CSR_RATE, rate);
      write_csr(CSR_WINDOW, window);
   endtask

   task automatic test_directed();
      sender_idling = 1'b0;
      receiver_idling = 1'b0;
      send_item(send_req(64'd5, 1'b1));
      send_item(push_req(16'd0, 64'd0));
      send_item(push_req(16'hFFFF, '1));
      send_item(push_req(16'd1234, 64'h0123_4567_89AB_CDEF));
      send_item(send_req(64'd7, 1'b0));
      send_item(send_req(64'd9, 1'b1));
      send_item(send_req(64'd11, 1'b1));
      // A window written below the minimum acts as the minimum.
      set_shaping(34'd1000, 34'd0);
      send_item(send_req(64'd1000, 1'b1));
      send_item(send_req(64'd0, 1'b0));
      send_item(send_req(64'd5, 1'b1));
      send_item(push_req(16'd800, 64'hFEDC_BA98_7654_3210));
      send_item(push_req(16'd900, 64'h8000_0000_0000_0001));
      send_item(send_req(64'd5, 1'b1));
      send_item(send_req(64'd5, 1'b1));
      send_item(send_req(64'd2005, 1'b1));
      send_item(send_req(64'd34005, 1'b1));
      send_item(send_req(64'd40000, 1'b1));
   endtask

   task automatic test_backpressure();
      set_shaping(34'd0, 34'hFF_FFFF);
      sender_idling = 1'b0;
      receiver_idling = 1'b1;
      hold_requests++;
      repeat (QUEUE_DEPTH + 6) send_item(push_req(16'($urandom), {$urandom, $urandom}));
      repeat (QUEUE_DEPTH + 6) send_item(send_req({$urandom, $urandom}, 1'b1));
   endtask

   task automatic test_debt_buildup();
      set_shaping(34'd0, 34'd2000);
      sender_idling = 1'b0;
      receiver_idling = 1'b0;
      repeat (100) begin
         send_item(push_req(16'hFFFF, {$urandom, $urandom}));
         send_item(send_req({$urandom, $urandom}, 1'b1));
      end
   endtask

   task automatic test_random_traffic();
      logic [CSR_DATA_W-1:0] rate;
      logic [CSR_DATA_W-1:0] window;
      logic [LEN_W-1:0]      len;
      int                    push_pct;
      int                    pick;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin
               rate = {RATE_W{1'b1}};
               window = 34'(MIN_WINDOW);
            end
            1: begin
               rate = '0;
               window = 34'd2000;
            end
            2: begin
               rate = 34'd1;
               window = 34'hFF_FFFF;
            end
            3: begin
               rate = 34'($urandom_range(100000, 5000000));
               window = 34'($urandom_range(2000, 100000));
            end
            4: begin
               rate = 34'd100000;
               window = {10'h3FF, 24'd1500};
            end
            5: begin
               rate = {2'($urandom), $urandom};
               window = 34'($urandom);
            end
            default: begin
               rate = 34'($urandom_range(200000, 3000000));
               window = 34'($urandom_range(2000, 30000));
            end
         endcase
         set_shaping(rate, window);
         sender_idling = (phase < 6);
         receiver_idling = (phase < 6);
         push_pct = $urandom_range(35, 65);
         repeat (PHASE_ITEMS) begin
            if ($urandom_range(99) < push_pct) begin
               pick = $urandom_range(99);
               if (pick < 5) begin
                  len = pick[0] ? 16'hFFFF : 16'd0;
               end else if (pick < 15) begin
                  len = 16'($urandom);
               end else begin
                  len = 16'($urandom_range(40, 1500));
               end
               send_item(push_req(len, {$urandom, $urandom}));
            end else begin
               pick = $urandom_range(99);
               if (pick < 4) begin
                  traffic_time = {$urandom, $urandom};
               end else if (pick < 9) begin
                  traffic_time = traffic_time - 64'($urandom_range(1, 100000));
               end else begin
                  traffic_time = traffic_time + 64'($urandom_range(4000));
               end
               send_item(send_req(traffic_time, $urandom_range(99) < 85));
            end
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_backpressure();
      test_debt_buildup();
      test_random_traffic();
      wait_for_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_wr == expected_rd) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
hdl/prs_pkg.sv
hdl/prs_ram.sv
hdl/prs_ctrl.sv
hdl/prs_dp.sv
hdl/packet_rate_shaper_top.sv
dv/packet_rate_shaper_top_tb.sv
